@@ sv/rloc_pkg.sv @@
// Package for the rectangle layout overlap checker: widths, codes and types.
`default_nettype none
package rloc_pkg;
	localparam int MAX_RECTS_DEF = 32;
	localparam int MAX_ISSUES_DEF = 64;
	localparam int CQ_DEPTH = 2;

	localparam logic [8:0] DISP_W_RST = 9'd128;
	localparam logic [8:0] DISP_H_RST = 9'd64;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_BOUNDS  = 2'd1,
		KIND_NESTING = 2'd2,
		KIND_OVERLAP = 2'd3
	} kind_t;

	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_ADD   = 1'b1;
	localparam logic CFG_DISP_W = 1'b0;
	localparam logic CFG_DISP_H = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] rect_x;
		logic [7:0] rect_y;
		logic [7:0] rect_width;
		logic [7:0] rect_height;
		logic [7:0] parent_index;
		logic       may_overlap;
	} cmd_t;

	typedef struct packed {
		logic [5:0] new_index;
		kind_t      issue_kind;
		logic [7:0] other_index;
		logic       last_result;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOUNDS,
		ST_NEST,
		ST_CAND,
		ST_WALK,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

@@ sv/rect_layout_overlap_checker_top.sv @@
// Top level of the rectangle layout overlap checker.
`default_nettype none
// The back end works on one command at a time while a two-entry queue takes new
// transactions. A clear, or an add to a full table, skips the scan. An add reads
// each earlier rectangle from the single-read-port table, plus an ancestor walk for
// each intersecting pair that is not exempt while the issue count is below capacity
// (at least one step, at most the chain depth in each direction). Most steps also
// stall while a result waits on m_axis_tready.
module rect_layout_overlap_checker_top
	import rloc_pkg::*;
#(
	parameter int MAX_RECTS = MAX_RECTS_DEF,
	parameter int MAX_ISSUES = MAX_ISSUES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire  [8:0] cfg_data,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [39:0] s_axis_tdata, // rect_x, rect_y, rect_width, rect_height, parent_index
	input  wire  [1:0]  s_axis_tuser, // command, may_overlap
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [15:0] m_axis_tdata, // new_index, other_index, zero pad
	output logic [1:0]  m_axis_tuser, // issue_kind
	output logic       m_axis_tlast
);
	logic [8:0] dw_q, dh_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q <= DISP_W_RST; dh_q <= DISP_H_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DISP_W) dw_q <= cfg_data;
			else dh_q <= cfg_data;
		end
	end

	cmd_t in_cmd, q_cmd;
	res_t res;
	logic q_valid, q_pop;
	assign in_cmd = '{command: s_axis_tuser[0], rect_x: s_axis_tdata[7:0],
		rect_y: s_axis_tdata[15:8], rect_width: s_axis_tdata[23:16],
		rect_height: s_axis_tdata[31:24], parent_index: s_axis_tdata[39:32],
		may_overlap: s_axis_tuser[1]};

	rloc_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd, .q_valid, .q_pop, .q_cmd);

	rloc_back #(.MAX_RECTS(MAX_RECTS), .MAX_ISSUES(MAX_ISSUES)) u_back (.clk, .arst_n,
		.disp_w(dw_q), .disp_h(dh_q), .q_valid, .q_pop, .q_cmd,
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_res(res));

	assign m_axis_tdata = {2'b00, res.other_index, res.new_index};
	assign m_axis_tuser = res.issue_kind;
	assign m_axis_tlast = res.last_result;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_BOUNDS |-> m_axis_tdata[13:6] == 8'hFF)
		else $error("bounds issue with other index");
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_NONE |-> m_axis_tlast)
		else $error("no-issue result not marked last");
endmodule
`default_nettype wire

@@ sv/rloc_front.sv @@
// Front end: accepts command transactions into a short queue.
`default_nettype none
module rloc_front
	import rloc_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic q_valid,
	input  wire  q_pop,
	output cmd_t q_cmd
);
	localparam int PW = $clog2(CQ_DEPTH);
	cmd_t mem_q [CQ_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;

	assign in_ready = (cnt_q != (PW+1)'(CQ_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (in_valid && in_ready) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(in_valid && in_ready) - (PW+1)'(q_pop);
		end
	end
endmodule
`default_nettype wire

@@ sv/rloc_back.sv @@
// Back end: stores rectangles, scans earlier entries and emits issue results.
`default_nettype none
module rloc_back
	import rloc_pkg::*;
#(
	parameter int MAX_RECTS = MAX_RECTS_DEF,
	parameter int MAX_ISSUES = MAX_ISSUES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire  [8:0] disp_w,
	input  wire  [8:0] disp_h,
	input  wire        q_valid,
	output logic       q_pop,
	input  cmd_t       q_cmd,
	output logic       o_valid,
	input  wire        o_ready,
	output res_t       o_res
);
	localparam int IW = $clog2(MAX_RECTS);
	localparam int CW = IW + 1;

	// table entry: x y w h parent ok
	logic [40:0] tab_q [MAX_RECTS];
	logic [40:0] rd_q;
	logic [IW-1:0] rd_addr;
	logic rd_en;

	state_t st_q, st_d;
	cmd_t cur_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] me_q, k_q, node_q;
	logic [5:0] new_q;
	logic dir_q;          // 0: does me descend from k, 1: does k descend from me
	logic [6:0] iss_q;
	// newest issue waits here until it is known whether it is the last one
	logic hold_q;
	res_t hold_res_q;
	logic pend_q;
	res_t pend_res_q;

	logic issue_en;
	kind_t issue_kind;
	logic [7:0] issue_other;
	logic done_push;
	logic out_push;
	res_t out_res;

	wire [8:0] rx = {1'b0, cur_q.rect_x};
	wire [8:0] ry = {1'b0, cur_q.rect_y};
	wire [8:0] rw = {1'b0, cur_q.rect_width};
	wire [8:0] rh = {1'b0, cur_q.rect_height};
	wire [8:0] ox = {1'b0, rd_q[40:33]};
	wire [8:0] oy = {1'b0, rd_q[32:25]};
	wire [8:0] ow = {1'b0, rd_q[24:17]};
	wire [8:0] oh = {1'b0, rd_q[16:9]};
	wire signed [7:0] opar = rd_q[8:1];
	wire signed [7:0] ppar = cur_q.parent_index;

	wire out_free = !pend_q || o_ready;
	wire cap_ok = (iss_q < 7'(MAX_ISSUES));

	wire bounds_bad = (rx + rw > disp_w) || (ry + rh > disp_h);
	wire par_fwd = (ppar >= $signed(8'(me_q)));
	wire holds = rx >= ox && ry >= oy && rx + rw <= ox + ow && ry + rh <= oy + oh;
	wire hit = rw != 0 && rh != 0 && ow != 0 && oh != 0 &&
		rx < ox + ow && ox < rx + rw && ry < oy + oh && oy < ry + rh;
	wire cand_ok = hit && !cur_q.may_overlap && !rd_q[0];

	// walk: node entry in rd_q, target anc
	wire [IW-1:0] anc = dir_q ? me_q : k_q;
	wire walk_hit = (opar == $signed(8'(anc)));
	wire walk_stop = opar[7] || (opar >= $signed(8'(node_q)));

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (q_valid) begin
				if (q_cmd.command == CMD_CLEAR || cnt_q == CW'(MAX_RECTS)) st_d = ST_DONE;
				else st_d = ST_BOUNDS;
			end
			ST_BOUNDS: if (out_free) st_d = ST_NEST;
			ST_NEST:   if (out_free) st_d = ST_CAND;
			ST_CAND: begin
				if (k_q == me_q) st_d = ST_DONE;
				else if (cand_ok && cap_ok) st_d = ST_WALK;
			end
			ST_WALK: if (out_free && (walk_hit || (walk_stop && dir_q))) st_d = ST_CAND;
			ST_DONE: if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// rd_q holds the parent in NEST, entry k in CAND, the walked node in WALK
	always_comb begin
		q_pop = 1'b0;
		rd_en = 1'b0; rd_addr = k_q;
		issue_en = 1'b0; issue_kind = KIND_NONE; issue_other = 8'hFF;
		case (st_q)
			ST_IDLE: q_pop = q_valid;
			ST_BOUNDS: if (out_free) begin
				issue_en = bounds_bad && cap_ok; issue_kind = KIND_BOUNDS;
				rd_en = 1'b1; rd_addr = cur_q.parent_index[IW-1:0];
			end
			ST_NEST: if (out_free) begin
				issue_en = !ppar[7] && (par_fwd || !holds) && cap_ok;
				issue_kind = KIND_NESTING; issue_other = cur_q.parent_index;
				rd_en = 1'b1; rd_addr = '0;
			end
			ST_CAND: if (k_q != me_q) begin
				rd_en = 1'b1;
				if (cand_ok && cap_ok) rd_addr = me_q;
				else rd_addr = k_q + 1'b1;
			end
			ST_WALK: if (out_free) begin
				rd_en = 1'b1;
				if (walk_hit || (walk_stop && dir_q)) begin
					rd_addr = k_q + 1'b1;
					issue_en = !walk_hit; issue_kind = KIND_OVERLAP;
					issue_other = 8'(k_q);
				end else if (walk_stop) rd_addr = k_q;
				else rd_addr = opar[IW-1:0];
			end
			default: ;
		endcase
	end

	assign done_push = (st_q == ST_DONE) && out_free;
	assign out_push = done_push || (issue_en && hold_q);

	always_comb begin
		out_res = hold_res_q;
		if (done_push) begin
			if (hold_q) out_res.last_result = 1'b1;
			else out_res = '{new_index: new_q, issue_kind: KIND_NONE, other_index: 8'hFF,
				last_result: 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.command == CMD_ADD && cnt_q != CW'(MAX_RECTS))
			tab_q[cnt_q[IW-1:0]] <= {q_cmd.rect_x, q_cmd.rect_y, q_cmd.rect_width,
				q_cmd.rect_height, q_cmd.parent_index, q_cmd.may_overlap};
		if (rd_en) rd_q <= tab_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; cnt_q <= '0; iss_q <= '0; pend_q <= 1'b0;
			k_q <= '0; me_q <= '0; node_q <= '0; dir_q <= 1'b0; new_q <= 6'h3F;
			cur_q <= '0; pend_res_q <= '0; hold_q <= 1'b0; hold_res_q <= '0;
		end else begin
			st_q <= st_d;
			if (out_push) begin
				pend_q <= 1'b1;
				pend_res_q <= out_res;
			end else if (o_ready) pend_q <= 1'b0;
			if (issue_en) begin
				hold_q <= 1'b1;
				hold_res_q <= '{new_index: new_q, issue_kind: issue_kind,
					other_index: issue_other, last_result: 1'b0};
				iss_q <= iss_q + 7'd1;
			end else if (done_push) hold_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (q_pop) begin
					cur_q <= q_cmd; k_q <= '0;
					me_q <= cnt_q[IW-1:0];
					if (q_cmd.command == CMD_CLEAR) begin
						cnt_q <= '0; iss_q <= '0; new_q <= 6'h3F;
					end else if (cnt_q != CW'(MAX_RECTS)) begin
						cnt_q <= cnt_q + 1'b1; new_q <= 6'(cnt_q[IW-1:0]);
					end else new_q <= 6'h3F;
				end
				ST_CAND: if (k_q != me_q) begin
					if (cand_ok && cap_ok) begin
						dir_q <= 1'b0; node_q <= me_q;
					end else k_q <= k_q + 1'b1;
				end
				ST_WALK: if (out_free) begin
					if (walk_hit || (walk_stop && dir_q)) k_q <= k_q + 1'b1;
					else if (walk_stop) begin
						dir_q <= 1'b1; node_q <= k_q;
					end else node_q <= opar[IW-1:0];
				end
				default: ;
			endcase
		end
	end

	assign o_valid = pend_q;
	assign o_res = pend_res_q;
endmodule
`default_nettype wire

@@ sim/rloc_scoreboard.sv @@
// Checker for the rectangle layout overlap checker: predicts and compares result transactions.
module rloc_scoreboard
	import rloc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [8:0]  cfg_data,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [39:0] s_axis_tdata,
	input  wire  [1:0]  s_axis_tuser,
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [15:0] m_axis_tdata,
	input  wire  [1:0]  m_axis_tuser,
	input  wire         m_axis_tlast,
	output int          fails,
	output int          outstanding,
	output int          n_results,
	output int          n_overlap,
	output int          n_nesting,
	output int          n_bounds,
	output int          n_full,
	output int          n_dropped
);
	localparam int NRECT = MAX_RECTS_DEF;
	localparam int NISSUE = MAX_ISSUES_DEF;

	int tab_x [NRECT];
	int tab_y [NRECT];
	int tab_w [NRECT];
	int tab_h [NRECT];
	int tab_par [NRECT];
	bit tab_ovl [NRECT];
	int stored;
	int issues;
	int disp_w;
	int disp_h;

	res_t expected_q [$];
	res_t batch [$];
	logic [5:0] cur_idx;

	function automatic bit boxes_hit(int a, int b);
		if (tab_w[a] == 0 || tab_h[a] == 0 || tab_w[b] == 0 || tab_h[b] == 0)
			return 0;
		return tab_x[a] < tab_x[b] + tab_w[b] && tab_x[b] < tab_x[a] + tab_w[a] &&
			tab_y[a] < tab_y[b] + tab_h[b] && tab_y[b] < tab_y[a] + tab_h[a];
	endfunction

	function automatic bit box_contains(int o, int i);
		return tab_x[i] >= tab_x[o] && tab_y[i] >= tab_y[o] &&
			tab_x[i] + tab_w[i] <= tab_x[o] + tab_w[o] &&
			tab_y[i] + tab_h[i] <= tab_y[o] + tab_h[o];
	endfunction

	// walk stops at a link that is negative or not strictly earlier
	function automatic bit is_ancestor(int anc, int node);
		int p;
		while (node >= 0 && node < NRECT) begin
			p = tab_par[node];
			if (p == anc)
				return 1;
			if (p < 0 || p >= node)
				return 0;
			node = p;
		end
		return 0;
	endfunction

	function automatic void note_issue(kind_t kind, int other);
		res_t r;
		if (issues >= NISSUE) begin
			n_dropped++;
			return;
		end
		issues++;
		r.new_index = cur_idx;
		r.issue_kind = kind;
		r.other_index = other[7:0];
		r.last_result = 1'b0;
		batch.push_back(r);
		case (kind)
			KIND_BOUNDS:  n_bounds++;
			KIND_NESTING: n_nesting++;
			KIND_OVERLAP: n_overlap++;
			default: ;
		endcase
	endfunction

	function automatic void predict_command(logic [1:0] user, logic [39:0] data);
		int me;
		int par;
		res_t r;
		batch.delete();
		cur_idx = 6'h3F;
		if (user[0] == CMD_CLEAR) begin
			stored = 0;
			issues = 0;
		end else if (stored < NRECT) begin
			me = stored;
			par = $signed(data[39:32]);
			tab_x[me] = data[7:0];
			tab_y[me] = data[15:8];
			tab_w[me] = data[23:16];
			tab_h[me] = data[31:24];
			tab_par[me] = par;
			tab_ovl[me] = user[1];
			stored++;
			cur_idx = me[5:0];
			if (tab_x[me] + tab_w[me] > disp_w || tab_y[me] + tab_h[me] > disp_h)
				note_issue(KIND_BOUNDS, -1);
			if (par >= 0)
				if (par >= me || !box_contains(par, me))
					note_issue(KIND_NESTING, par);
			for (int k = 0; k < me; k++)
				if (boxes_hit(me, k) && !tab_ovl[me] && !tab_ovl[k] &&
						!is_ancestor(k, me) && !is_ancestor(me, k))
					note_issue(KIND_OVERLAP, k);
		end else
			n_full++;
		if (batch.size() == 0) begin
			r.new_index = cur_idx;
			r.issue_kind = KIND_NONE;
			r.other_index = 8'hFF;
			r.last_result = 1'b0;
			batch.push_back(r);
		end
		batch[batch.size() - 1].last_result = 1'b1;
		foreach (batch[i])
			expected_q.push_back(batch[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		if (!arst_n) begin
			stored = 0;
			issues = 0;
			disp_w = DISP_W_RST;
			disp_h = DISP_H_RST;
			expected_q.delete();
			outstanding = 0;
			fails = 0;
			n_results = 0;
			n_overlap = 0;
			n_nesting = 0;
			n_bounds = 0;
			n_full = 0;
			n_dropped = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_DISP_W)
					disp_w = cfg_data;
				else
					disp_h = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				if (expected_q.size() == 0) begin
					$error("unexpected result transaction tdata=%h", m_axis_tdata);
					fails++;
				end else begin
					exp_r = expected_q.pop_front();
					if (m_axis_tdata[5:0] !== exp_r.new_index) begin
						$error("new_index expected %0d actual %0d",
							$signed(exp_r.new_index), $signed(m_axis_tdata[5:0]));
						fails++;
					end
					if (m_axis_tuser !== exp_r.issue_kind) begin
						$error("issue_kind expected %0d actual %0d",
							exp_r.issue_kind, m_axis_tuser);
						fails++;
					end
					if (m_axis_tdata[13:6] !== exp_r.other_index) begin
						$error("other_index expected %0d actual %0d",
							$signed(exp_r.other_index), $signed(m_axis_tdata[13:6]));
						fails++;
					end
					if (m_axis_tlast !== exp_r.last_result) begin
						$error("last_result expected %0d actual %0d",
							exp_r.last_result, m_axis_tlast);
						fails++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_command(s_axis_tuser, s_axis_tdata);
			outstanding = expected_q.size();
		end
	end
endmodule

@@ sim/rect_layout_overlap_checker_top_test.sv @@
// Testbench top for the rectangle layout overlap checker: stimulus, watchdog and verdict.
module rect_layout_overlap_checker_top_test;
	import rloc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int ITEMS_PER_PHASE = 60;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [8:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int fails, outstanding, n_results, n_overlap, n_nesting, n_bounds, n_full, n_dropped;
	int sent;
	int idle_cycles;
	bit long_hold_req;

	// shadow of stored boxes, used to build well-formed children
	int sh_x [32];
	int sh_y [32];
	int sh_w [32];
	int sh_h [32];
	int sh_cnt;

	rect_layout_overlap_checker_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	rloc_scoreboard chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.fails(fails), .outstanding(outstanding), .n_results(n_results),
		.n_overlap(n_overlap), .n_nesting(n_nesting), .n_bounds(n_bounds),
		.n_full(n_full), .n_dropped(n_dropped)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random ready pattern, plus one long hold-off on request
	initial begin
		int run;
		m_axis_tready = 1'b0;
		run = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (run == 0) begin
				if (!m_axis_tready || $urandom_range(0, 2) == 0) begin
					m_axis_tready <= !m_axis_tready;
					if (m_axis_tready)
						run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
							: $urandom_range(0, 3);
					else
						run = $urandom_range(1, 30);
				end else
					run = $urandom_range(1, 20);
			end else
				run--;
		end
	end

	task automatic write_reg(logic idx, logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_cmd(logic cmd, int x, int y, int w, int h, logic [7:0] par,
			logic ovl);
		int g;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {par, h[7:0], w[7:0], y[7:0], x[7:0]};
		s_axis_tuser <= {ovl, cmd};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		sent++;
		if (cmd == CMD_CLEAR)
			sh_cnt = 0;
		else if (sh_cnt < 32) begin
			sh_x[sh_cnt] = x[7:0];
			sh_y[sh_cnt] = y[7:0];
			sh_w[sh_cnt] = w[7:0];
			sh_h[sh_cnt] = h[7:0];
			sh_cnt++;
		end
		g = $urandom_range(0, 99);
		if (g >= 60) begin
			s_axis_tvalid <= 1'b0;
			if (g < 92)
				repeat ($urandom_range(1, 3)) @(posedge clk);
			else
				repeat ($urandom_range(10, 60)) @(posedge clk);
		end
	endtask

	task automatic add_random;
		int r, p, x, y, w, h, ex, ey;
		logic [7:0] par;
		r = $urandom_range(0, 99);
		x = $urandom_range(0, 120);
		y = $urandom_range(0, 60);
		w = $urandom_range(0, 40);
		h = $urandom_range(0, 30);
		par = 8'hFF;
		if (sh_cnt > 0 && r < 60) begin
			p = $urandom_range(0, sh_cnt - 1);
			ex = (sh_x[p] + sh_w[p] > 255) ? 255 : sh_x[p] + sh_w[p];
			ey = (sh_y[p] + sh_h[p] > 255) ? 255 : sh_y[p] + sh_h[p];
			x = $urandom_range(sh_x[p], ex);
			y = $urandom_range(sh_y[p], ey);
			w = $urandom_range(0, ex - x);
			h = $urandom_range(0, ey - y);
			if ($urandom_range(0, 7) == 0)
				w = w + 1;
			par = p[7:0];
		end else if (r < 88 && r >= 75)
			par = 8'($urandom_range(0, 127));
		else if (r >= 88)
			par = 8'($urandom_range(0, 255));
		send_cmd(CMD_ADD, x, y, w, h, par, $urandom_range(0, 4) == 0);
	endtask

	// the first edge is waited out so that the checker has seen the last transaction
	task automatic wait_drained;
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int phase, target, k, n;
		int widths [6] = '{128, 510, 1, 300, 510, 64};
		int heights [6] = '{64, 510, 1, 200, 1, 510};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DISP_W;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		idle_cycles = 0;
		long_hold_req = 1'b0;
		sent = 0;
		sh_cnt = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and each issue kind
		send_cmd(CMD_CLEAR, 0, 0, 0, 0, 8'hFF, 0);
		send_cmd(CMD_ADD, 0, 0, 100, 50, 8'hFF, 0);
		send_cmd(CMD_ADD, 10, 10, 20, 20, 8'd0, 0);
		send_cmd(CMD_ADD, 15, 15, 5, 5, 8'd1, 0);
		send_cmd(CMD_ADD, 90, 40, 30, 20, 8'd0, 0);
		send_cmd(CMD_ADD, 20, 20, 10, 10, 8'hFF, 0);
		send_cmd(CMD_ADD, 20, 20, 10, 10, 8'hFF, 1);
		send_cmd(CMD_ADD, 20, 20, 0, 10, 8'hFF, 0);
		send_cmd(CMD_ADD, 20, 20, 10, 0, 8'hFF, 0);
		send_cmd(CMD_ADD, 5, 5, 10, 10, 8'd50, 0);
		send_cmd(CMD_ADD, 5, 5, 10, 10, 8'd127, 0);
		send_cmd(CMD_ADD, 255, 255, 255, 255, 8'hFF, 0);
		send_cmd(CMD_ADD, 0, 0, 128, 64, 8'hFF, 1);
		send_cmd(CMD_ADD, 0, 0, 129, 64, 8'hFF, 1);
		send_cmd(CMD_ADD, 0, 0, 128, 65, 8'h80, 1);
		send_cmd(CMD_ADD, 30, 30, 10, 10, 8'd12, 0);
		send_cmd(CMD_CLEAR, 255, 255, 255, 255, 8'h7F, 1);
		send_cmd(CMD_ADD, 1, 1, 1, 1, 8'hFF, 0);
		send_cmd(CMD_ADD, 1, 1, 1, 1, 8'd0, 0);
		wait_drained();

		for (phase = 0; phase < 6; phase++) begin
			write_reg(CFG_DISP_W, 9'(widths[phase]));
			write_reg(CFG_DISP_H, 9'(heights[phase]));
			if (phase == 2)
				long_hold_req = 1'b1;
			target = sent + ITEMS_PER_PHASE;
			while (sent < target) begin
				k = $urandom_range(0, 99);
				if (k < 8)
					send_cmd(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else if (k < 16) begin
					// stacked identical boxes: can drive the issue count to its cap
					send_cmd(CMD_CLEAR, 0, 0, 0, 0, 8'hFF, 0);
					n = $urandom_range(6, 14);
					repeat (n) send_cmd(CMD_ADD, 3, 3, 8, 8, 8'hFF, 0);
				end else if (k < 24)
					send_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				else if (k < 28) begin
					// fill past table capacity
					repeat (34 - sh_cnt) add_random();
				end else
					add_random();
			end
			wait_drained();
		end

		wait_drained();
		repeat (100) @(posedge clk);
		$display("covered %0d commands, %0d results: %0d overlap, %0d nesting, %0d bounds",
			sent, n_results, n_overlap, n_nesting, n_bounds);
		$display("table-full adds %0d, issues dropped at capacity %0d", n_full, n_dropped);
		if (fails == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
